// ----- hw/rtl/brds_pkg.sv -----
// Shared constants and types for the budgeted range drain scheduler.
`default_nettype none
package brds_pkg;

   localparam int MAX_RANGES = 64;
   localparam int LINE_BITS  = 24;
   localparam int REG_BITS   = 24;
   localparam int PEND_BITS  = 31;
   localparam int IDX_BITS   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);
   localparam int SPAN_BITS  = LINE_BITS + 1;
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_LINE_TOTAL    = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TICK_BUDGET   = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_VIEWPORT_LOW  = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_VIEWPORT_HIGH = 2'd3;

   localparam logic OP_MARK = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic [LINE_BITS-1:0] last;
      logic [LINE_BITS-1:0] first;
   } range_entry_type;

endpackage
`default_nettype wire

// ----- hw/rtl/budgeted_range_drain_scheduler.sv -----
// Top level of the budgeted range drain scheduler: sequencer, table control and result register.
//
// Input transactions arrive on req_*: tuser carries the operation (mark or tick), tdata the
// range bounds. Each input transaction produces exactly one result transaction on rsp_*.
// The user writes configuration registers through csr_* only while the block is idle; the
// block itself does not enforce this.
// A mark goes from ST_MARK straight to ST_DONE when it is rejected or clips to nothing, and
// through ST_APPEND otherwise; when the table is full, a coalescing scan in ST_MERGE comes
// first and reads one table entry per cycle from the single read port.
// A tick sets up the viewport in ST_VIEW, then makes up to two passes over the table in
// ST_EVAL, looking at one entry at a time; an entry drained completely takes an extra ST_MOVE
// step to move the last entry into its slot. Both load their result in ST_DONE.
// req_tready is high only in the idle state, so a new transaction can be accepted in the
// cycle after the previous result is loaded.
// The result is held in an output register; the next item is accepted and worked on while
// a result waits, and the sequencer holds its own result until the register is free.
// Reset is synchronous; it empties the table and restores register defaults, with no
// clearing pass.
`default_nettype none
module budgeted_range_drain_scheduler
   import brds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // range_low[23:0], range_high[47:24]
   input  wire logic [0:0]  req_tuser,   // op[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // rejected[0], lines_done[24:1],
                                         // pending_lines[55:25], idle[56], zero fill
   input  wire logic        csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [REG_BITS-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MARK   = 9'b000000010,
      ST_MERGE  = 9'b000000100,
      ST_APPEND = 9'b000001000,
      ST_VIEW   = 9'b000010000,
      ST_EVAL   = 9'b000100000,
      ST_MOVE   = 9'b001000000,
      ST_DONE   = 9'b010000000,
      ST_SPARE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [REG_BITS-1:0] line_total_ff, tick_budget_ff, vp_low_ff, vp_high_ff;

   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [PEND_BITS-1:0] pend_ff, pend_in;
   logic [LINE_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [LINE_BITS-1:0] vh_ff, vh_in, vl_ff, vl_in;
   logic [REG_BITS-1:0]  remain_ff, remain_in, done_ff, done_in;
   logic                 rej_ff, rej_in, pass_ff, pass_in;
   range_entry_type      acc_ff, acc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr, rd_addr;
   range_entry_type      wr_data, rd_data, merged;

   logic [LINE_BITS-1:0] lt_minus1, hi_clip, vh_calc;
   logic [SPAN_BITS-1:0] span;
   logic [CNT_BITS-1:0]  cnt_dec;
   logic                 inview, load_rsp;

   brds_range_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_total_ff  <= '0;
         tick_budget_ff <= REG_BITS'(64);
         vp_low_ff      <= '0;
         vp_high_ff     <= '1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LINE_TOTAL:    line_total_ff  <= csr_wdata;
            CSR_TICK_BUDGET:   tick_budget_ff <= csr_wdata;
            CSR_VIEWPORT_LOW:  vp_low_ff      <= csr_wdata;
            CSR_VIEWPORT_HIGH: vp_high_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign lt_minus1 = line_total_ff - LINE_BITS'(1);
   assign hi_clip   = (hi_ff > lt_minus1) ? lt_minus1 : hi_ff;
   assign vh_calc   = (line_total_ff == '0) ? '0 :
                      ((vp_high_ff < lt_minus1) ? vp_high_ff : lt_minus1);
   assign span      = SPAN_BITS'(rd_data.last) - SPAN_BITS'(rd_data.first) + SPAN_BITS'(1);
   assign inview    = (rd_data.first <= vh_ff) && (rd_data.last >= vl_ff);
   assign cnt_dec   = cnt_ff - CNT_BITS'(1);
   assign load_rsp  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      merged.first = (idx_ff == '0 || rd_data.first < acc_ff.first) ? rd_data.first
                                                                     : acc_ff.first;
      merged.last  = (idx_ff == '0 || rd_data.last > acc_ff.last) ? rd_data.last
                                                                   : acc_ff.last;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      vh_in     = vh_ff;
      vl_in     = vl_ff;
      remain_in = remain_ff;
      done_in   = done_ff;
      rej_in    = rej_ff;
      pass_in   = pass_ff;
      acc_in    = acc_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[IDX_BITS-1:0];
      wr_data   = rd_data;
      rd_addr   = idx_ff[IDX_BITS-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in    = '0;
               rej_in    = 1'b0;
               done_in   = '0;
               pass_in   = 1'b0;
               lo_in     = req_tdata[LINE_BITS-1:0];
               hi_in     = req_tdata[24 +: LINE_BITS];
               vh_in     = vh_calc;
               remain_in = tick_budget_ff;
               state_in  = (req_tuser[0] == OP_TICK) ? ST_VIEW : ST_MARK;
            end
         end
         ST_MARK: begin
            if (hi_ff < lo_ff) begin
               rej_in   = 1'b1;
               state_in = ST_DONE;
            end else if (line_total_ff == '0 || lo_ff > hi_clip) begin
               state_in = ST_DONE;
            end else begin
               hi_in    = hi_clip;
               state_in = (cnt_ff == CNT_BITS'(MAX_RANGES)) ? ST_MERGE : ST_APPEND;
            end
         end
         ST_MERGE: begin
            acc_in  = merged;
            idx_in  = idx_ff + CNT_BITS'(1);
            rd_addr = idx_in[IDX_BITS-1:0];
            if (idx_in == cnt_ff) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = merged;
               cnt_in   = CNT_BITS'(1);
               pend_in  = PEND_BITS'(merged.last) - PEND_BITS'(merged.first)
                          + PEND_BITS'(1);
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            wr_en         = 1'b1;
            wr_addr       = cnt_ff[IDX_BITS-1:0];
            wr_data.first = lo_ff;
            wr_data.last  = hi_ff;
            cnt_in        = cnt_ff + CNT_BITS'(1);
            pend_in       = pend_ff + PEND_BITS'(hi_ff) - PEND_BITS'(lo_ff) + PEND_BITS'(1);
            state_in      = ST_DONE;
         end
         ST_VIEW: begin
            vl_in    = (vp_low_ff < vh_ff) ? vp_low_ff : vh_ff;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (idx_ff >= cnt_ff || remain_ff == '0) begin
               if (!pass_ff && remain_ff != '0) begin
                  pass_in = 1'b1;
                  idx_in  = '0;
                  rd_addr = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (pass_ff == inview) begin
               idx_in  = idx_ff + CNT_BITS'(1);
               rd_addr = idx_in[IDX_BITS-1:0];
            end else if (span <= SPAN_BITS'(remain_ff)) begin
               remain_in = remain_ff - span[REG_BITS-1:0];
               done_in   = done_ff + span[REG_BITS-1:0];
               pend_in   = pend_ff - PEND_BITS'(span);
               cnt_in    = cnt_dec;
               rd_addr   = cnt_dec[IDX_BITS-1:0];
               state_in  = ST_MOVE;
            end else begin
               wr_en         = 1'b1;
               wr_data.first = rd_data.first + remain_ff;
               wr_data.last  = rd_data.last;
               done_in       = done_ff + remain_ff;
               pend_in       = pend_ff - PEND_BITS'(remain_ff);
               remain_in     = '0;
               state_in      = ST_DONE;
            end
         end
         ST_MOVE: begin
            // The moved entry still sits at its old slot, so reading it there returns the
            // new content of the current slot in the next cycle.
            wr_en    = 1'b1;
            wr_data  = rd_data;
            rd_addr  = cnt_ff[IDX_BITS-1:0];
            state_in = ST_EVAL;
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, (cnt_ff == '0), pend_ff, done_ff, rej_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      vh_ff       <= vh_in;
      vl_ff       <= vl_in;
      remain_ff   <= remain_in;
      done_ff     <= done_in;
      rej_ff      <= rej_in;
      pass_ff     <= pass_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/brds_range_ram.sv -----
// Range table memory with one write port and one registered read port.
`default_nettype none
module brds_range_ram
   import brds_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [IDX_BITS-1:0] wr_addr,
   input  wire range_entry_type wr_data,
   input  wire logic [IDX_BITS-1:0] rd_addr,
   output range_entry_type      rd_data
);

   range_entry_type mem_ff [MAX_RANGES];
   range_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the budgeted range drain scheduler with its own table predictor.
module tb_top;
   import brds_pkg::*;

   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          RANDOM_PHASES  = 16;
   localparam int          PHASE_ITEMS    = 95;
   localparam logic [23:0] LINE_MAX       = 24'hFFFFFF;

   typedef struct packed {
      logic                 rejected;
      logic [REG_BITS-1:0]  lines_done;
      logic [PEND_BITS-1:0] pending_lines;
      logic                 idle;
   } drain_status_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [47:0]              req_tdata;    // range_low[23:0], range_high[47:24]
   logic [0:0]               req_tuser;    // op[0]
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [63:0]              rsp_tdata;    // rejected[0], lines_done[24:1],
                                           // pending_lines[55:25], idle[56], zero fill
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [REG_BITS-1:0]      csr_wdata;

   budgeted_range_drain_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [LINE_BITS-1:0] tbl_first [MAX_RANGES];
   logic [LINE_BITS-1:0] tbl_last  [MAX_RANGES];
   int                   tbl_count     = 0;
   logic [REG_BITS-1:0]  line_total_r  = 24'd0;
   logic [REG_BITS-1:0]  tick_budget_r = 24'd64;
   logic [REG_BITS-1:0]  view_low_r    = 24'd0;
   logic [REG_BITS-1:0]  view_high_r   = LINE_MAX;

   drain_status_type expected_q [$];
   int            errors            = 0;
   int            marks_sent        = 0;
   int            ticks_sent        = 0;
   int            rejects_predicted = 0;
   int            merges_predicted  = 0;
   int            results_checked   = 0;
   int            stuck_cycles      = 0;
   int            sink_hold_len     = 0;
   bit            throttle          = 1'b1;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [PEND_BITS-1:0] pending_total();
      longint unsigned sum;
      sum = 0;
      for (int i = 0; i < tbl_count; i++) sum += tbl_last[i] - tbl_first[i] + 1;
      if (sum > 64'h7FFF_FFFF) sum = 64'h7FFF_FFFF;
      return sum[PEND_BITS-1:0];
   endfunction

   function automatic logic mark_range(logic [23:0] lo, logic [23:0] hi);
      logic [23:0] top;
      if (hi < lo) return 1'b1;
      if (line_total_r == 24'd0) return 1'b0;
      top = (hi > line_total_r - 24'd1) ? line_total_r - 24'd1 : hi;
      if (lo > top) return 1'b0;
      if (tbl_count >= MAX_RANGES) begin
         for (int i = 1; i < tbl_count; i++) begin
            if (tbl_first[i] < tbl_first[0]) tbl_first[0] = tbl_first[i];
            if (tbl_last[i] > tbl_last[0]) tbl_last[0] = tbl_last[i];
         end
         tbl_count = 1;
         merges_predicted++;
      end
      tbl_first[tbl_count] = lo;
      tbl_last[tbl_count]  = top;
      tbl_count++;
      return 1'b0;
   endfunction

   function automatic logic [23:0] drain_tick();
      logic [23:0]     vh;
      logic [23:0]     vl;
      longint unsigned remaining;
      longint unsigned drained;
      longint unsigned span;
      longint unsigned take;
      int              i;
      bit              in_view;
      vh = (line_total_r == 24'd0) ? 24'd0 : line_total_r - 24'd1;
      if (view_high_r < vh) vh = view_high_r;
      vl = (view_low_r < vh) ? view_low_r : vh;
      remaining = tick_budget_r;
      drained   = 0;
      for (int pass = 0; pass < 2 && remaining > 0; pass++) begin
         i = 0;
         while (i < tbl_count && remaining > 0) begin
            in_view = (tbl_first[i] <= vh) && (tbl_last[i] >= vl);
            if ((pass == 0) != in_view) begin
               i++;
            end else begin
               span = tbl_last[i] - tbl_first[i] + 1;
               take = (span < remaining) ? span : remaining;
               remaining -= take;
               drained   += take;
               if (take == span) begin
                  tbl_count--;
                  tbl_first[i] = tbl_first[tbl_count];
                  tbl_last[i]  = tbl_last[tbl_count];
               end else begin
                  tbl_first[i] = tbl_first[i] + take[23:0];
                  i++;
               end
            end
         end
      end
      return drained[23:0];
   endfunction

   function automatic drain_status_type advance_table(logic op, logic [23:0] lo,
                                                      logic [23:0] hi);
      drain_status_type st;
      st = '0;
      if (op == OP_MARK) begin
         st.rejected = mark_range(lo, hi);
         marks_sent++;
         if (st.rejected) rejects_predicted++;
      end else begin
         st.lines_done = drain_tick();
         ticks_sent++;
      end
      st.pending_lines = pending_total();
      st.idle          = (tbl_count == 0);
      return st;
   endfunction

   task automatic send_item(logic op, logic [23:0] lo, logic [23:0] hi);
      int gap;
      req_tuser  = op;
      req_tdata  = {hi, lo};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(advance_table(op, lo, hi));
      @(negedge clock);
      gap = (throttle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_BITS-1:0] addr, logic [23:0] value);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (addr)
         CSR_LINE_TOTAL:    line_total_r  = value;
         CSR_TICK_BUDGET:   tick_budget_r = value;
         CSR_VIEWPORT_LOW:  view_low_r    = value;
         CSR_VIEWPORT_HIGH: view_high_r   = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic [23:0] lt, logic [23:0] budget, logic [23:0] vlo,
                            logic [23:0] vhi);
      wait_idle();
      write_reg(CSR_LINE_TOTAL, lt);
      write_reg(CSR_TICK_BUDGET, budget);
      write_reg(CSR_VIEWPORT_LOW, vlo);
      write_reg(CSR_VIEWPORT_HIGH, vhi);
   endtask

   task automatic send_random(int mark_pct);
      int              r;
      longint unsigned lt;
      longint unsigned lo;
      longint unsigned hi;
      logic            op;
      r  = $urandom_range(0, 99);
      lt = line_total_r;
      lo = $urandom_range(0, LINE_MAX);
      hi = $urandom_range(0, LINE_MAX);
      if (r < 8) begin
         op = 1'($urandom_range(0, 1));
      end else if (r < 12) begin
         op = OP_MARK;
         lo = $urandom_range(1, LINE_MAX);
         hi = $urandom_range(0, lo - 1);
      end else if (r < mark_pct) begin
         op = OP_MARK;
         if (lt != 0 && $urandom_range(0, 9) != 0) lo = $urandom_range(0, lt - 1);
         if ($urandom_range(0, 7) == 0) hi = lo + $urandom_range(0, 4095);
         else hi = lo + $urandom_range(0, 15);
         if ($urandom_range(0, 9) == 0) hi = $urandom_range(lo, LINE_MAX);
         if (hi > LINE_MAX) hi = LINE_MAX;
      end else begin
         op = OP_TICK;
      end
      send_item(op, lo[23:0], hi[23:0]);
   endtask

   task automatic test_directed_cases();
      // With no lines present a mark stores nothing.
      send_item(OP_MARK, 24'd0, 24'd0);
      send_item(OP_TICK, 24'd0, 24'd0);
      send_item(OP_MARK, 24'd5, 24'd4);
      configure(LINE_MAX, LINE_MAX, 24'd0, LINE_MAX);
      send_item(OP_MARK, 24'd0, LINE_MAX);
      send_item(OP_MARK, LINE_MAX, LINE_MAX);
      send_item(OP_MARK, LINE_MAX, 24'd0);
      send_item(OP_TICK, LINE_MAX, LINE_MAX);
      // Clipping to the line count, and a tick with no budget.
      configure(24'd100, 24'd0, 24'd0, LINE_MAX);
      send_item(OP_MARK, 24'd50, 24'd500);
      send_item(OP_MARK, 24'd200, 24'd300);
      send_item(OP_TICK, 24'd0, 24'd0);
      // The line count shrinks below stored ranges, and the viewport is inverted.
      configure(24'd10, 24'd7, 24'd60, 24'd5);
      send_item(OP_MARK, 24'd0, 24'd3);
      send_item(OP_MARK, 24'd5, 24'd9);
      repeat (3) send_item(OP_TICK, 24'd0, 24'd0);
      configure(24'd10, 24'd1, 24'd0, LINE_MAX);
      send_item(OP_TICK, 24'd0, 24'd0);
      configure(24'd10, LINE_MAX, 24'd0, LINE_MAX);
      send_item(OP_TICK, 24'd0, 24'd0);
   endtask

   task automatic test_backpressure();
      configure(24'd5000, 24'd32, 24'd100, 24'd900);
      throttle      = 1'b0;
      sink_hold_len = 400;
      repeat (24) send_random(60);
      throttle = 1'b1;
   endtask

   task automatic test_random_phases();
      logic [23:0] lt;
      logic [23:0] budget;
      logic [23:0] vlo;
      logic [23:0] vhi;
      int          mark_pct;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0:       lt = 24'd0;
            1:       lt = LINE_MAX;
            2, 3:    lt = 24'($urandom_range(0, LINE_MAX));
            4, 5, 6: lt = 24'($urandom_range(1, 200));
            default: lt = 24'($urandom_range(1000, 70000));
         endcase
         case ($urandom_range(0, 9))
            0:       budget = 24'd0;
            1:       budget = LINE_MAX;
            2, 3, 4: budget = 24'($urandom_range(1, 8));
            9:       budget = 24'($urandom_range(0, LINE_MAX));
            default: budget = 24'($urandom_range(9, 300));
         endcase
         vlo = ($urandom_range(0, 7) == 0) ? LINE_MAX : 24'($urandom_range(0, lt));
         vhi = ($urandom_range(0, 7) == 0) ? LINE_MAX : 24'($urandom_range(0, lt));
         if (p == 0) begin
            lt = LINE_MAX; budget = LINE_MAX; vlo = 24'd0; vhi = LINE_MAX;
         end else if (p == 1) begin
            lt = 24'd1; budget = 24'd1; vlo = LINE_MAX; vhi = 24'd0;
         end
         // Every third phase but the first keeps the budget small so that the table fills and coalesces.
         mark_pct = (p % 3 == 0) ? 90 : 60;
         if (p % 3 == 0 && p != 0) budget = 24'($urandom_range(1, 4));
         configure(lt, budget, vlo, vhi);
         throttle = (p % 4 != 2);
         repeat (PHASE_ITEMS) send_random(mark_pct);
      end
      throttle = 1'b1;
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_len > 0) begin
            rsp_tready = 1'b0;
            repeat (sink_hold_len - 1) @(negedge clock);
            sink_hold_len = 0;
         end else if (throttle && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat (pick_gap() - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      drain_status_type want;
      drain_status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rejected      = rsp_tdata[0];
         got.lines_done    = rsp_tdata[24:1];
         got.pending_lines = rsp_tdata[55:25];
         got.idle          = rsp_tdata[56];
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction 0x%h", rsp_tdata);
            errors++;
         end else begin
            want = expected_q.pop_front();
            results_checked++;
            if (got.rejected !== want.rejected) begin
               $error("rejected: expected %0d, actual %0d", want.rejected, got.rejected);
               errors++;
            end
            if (got.lines_done !== want.lines_done) begin
               $error("lines_done: expected %0d, actual %0d", want.lines_done, got.lines_done);
               errors++;
            end
            if (got.pending_lines !== want.pending_lines) begin
               $error("pending_lines: expected %0d, actual %0d", want.pending_lines,
                      got.pending_lines);
               errors++;
            end
            if (got.idle !== want.idle) begin
               $error("idle: expected %0d, actual %0d", want.idle, got.idle);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", expected_q.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_backpressure();
      test_random_phases();
      wait_idle();
      $display("Sent %0d marks (%0d rejected) and %0d ticks; the table coalesced %0d times.",
               marks_sent, rejects_predicted, ticks_sent, merges_predicted);
      $display("Checked %0d results over %0d random register settings and a long stall.",
               results_checked, RANDOM_PHASES);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/brds_pkg.sv
hw/rtl/brds_range_ram.sv
hw/rtl/budgeted_range_drain_scheduler.sv
test/tb_top.sv
